@@ hw/rtl/sad_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sad_pkg;

  localparam int unsigned CONS_COUNT = 16;
  localparam int unsigned VOWEL_COUNT = 4;

  localparam logic [4:0] KEPT_TOTAL = 5'd16;

  localparam logic [7:0] CH_END = 8'h00;
  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [7:0] CONS_TABLE [CONS_COUNT] = '{
    8'h42, 8'h44, 8'h46, 8'h47, 8'h4a, 8'h4b, 8'h4c, 8'h4d,
    8'h4e, 8'h50, 8'h52, 8'h53, 8'h54, 8'h56, 8'h57, 8'h5a
  };

  localparam logic [7:0] VOWEL_TABLE [VOWEL_COUNT] = '{
    8'h41, 8'h45, 8'h49, 8'h4f
  };

  typedef struct packed {
    logic [4:0]  kept_count;
    logic [47:0] accumulated_bits;
    logic        bad_letter;
    logic        ended;
  } dec_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/syllable_address_decoder_unit.sv @@
// Syllable address decoder.
// Input channel: one character byte per transfer on ch, with last marking the
// final character of a string. Separators are dropped, lowercase is folded,
// and the first sixteen kept characters are decoded as consonant/vowel pairs.
// Output channel: one transfer per string, sent for the character marked last,
// carrying ip_word, port_number and status (1 on bad length or bad letter;
// the address fields are then zero).
// A character is taken every cycle unless in_stall is high. Each transfer first
// lands in an input register; from there the decode logic updates the string
// state and, for a last character, loads the result register.
// When the result register is full and out_stall is high, a last character
// waits in the input register and in_stall rises; other characters keep
// flowing. Reset empties both registers and clears the string state.
`timescale 1ns / 1ps
`default_nettype none
module syllable_address_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  ch,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      ip_word,
  output logic [15:0]      port_number,
  output logic             status
);
  import sad_pkg::*;

  logic       stg_valid;
  logic [7:0] stg_ch;
  logic       stg_last;

  dec_state_t state;
  dec_state_t state_next;

  logic [31:0] res_ip;
  logic [15:0] res_port;
  logic        res_status;

  logic out_free;
  logic proc_go;

  sad_char_step u_step (
    .ch  (stg_ch),
    .cur (state),
    .nxt (state_next)
  );

  sad_result u_result (
    .fin         (state_next),
    .ip_word     (res_ip),
    .port_number (res_port),
    .status      (res_status)
  );

  assign out_free = !out_valid || !out_stall;
  assign proc_go = stg_valid && (!stg_last || out_free);
  assign in_stall = stg_valid && !proc_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (!in_stall) begin
      stg_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      stg_ch <= ch;
      stg_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (proc_go) begin
      if (stg_last) begin
        state <= '0;
      end else begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_go && stg_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (proc_go && stg_last) begin
      ip_word <= res_ip;
      port_number <= res_port;
      status <= res_status;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sad_char_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sad_char_step (
  input  wire logic [7:0]          ch,
  input  wire sad_pkg::dec_state_t cur,
  output sad_pkg::dec_state_t      nxt
);
  import sad_pkg::*;

  logic [7:0] upper;
  logic       is_sep;
  logic       skip;
  logic [3:0] cons_idx;
  logic       cons_hit;
  logic [1:0] vowel_pos;
  logic       vowel_hit;

  always_comb begin
    upper = (ch inside {[8'h61:8'h7a]}) ? ch - CASE_OFFSET : ch;
    is_sep = ch inside {CH_DASH, CH_SPACE, CH_DOT, CH_UNDER};
    skip = cur.ended || (cur.kept_count >= KEPT_TOTAL);

    cons_idx = '0;
    cons_hit = 1'b0;
    for (int i = 0; i < CONS_COUNT; i++) begin
      if (CONS_TABLE[i] == upper) begin
        cons_idx = 4'(i);
        cons_hit = 1'b1;
      end
    end

    vowel_pos = '0;
    vowel_hit = 1'b0;
    for (int i = 0; i < VOWEL_COUNT; i++) begin
      if (VOWEL_TABLE[i] == upper) begin
        vowel_pos = 2'(i);
        vowel_hit = 1'b1;
      end
    end

    nxt = cur;
    if (!skip) begin
      if (ch == CH_END) begin
        nxt.ended = 1'b1;
      end else if (!is_sep) begin
        if (!cur.kept_count[0]) begin
          nxt.accumulated_bits = {cur.accumulated_bits[43:0], cons_idx};
          nxt.bad_letter = cur.bad_letter || !cons_hit;
        end else begin
          nxt.accumulated_bits = {cur.accumulated_bits[45:0], vowel_pos};
          nxt.bad_letter = cur.bad_letter || !vowel_hit;
        end
        nxt.kept_count = cur.kept_count + 5'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sad_result.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sad_result (
  input  wire sad_pkg::dec_state_t fin,
  output logic [31:0]              ip_word,
  output logic [15:0]              port_number,
  output logic                     status
);
  import sad_pkg::*;

  logic [47:0] acc;

  always_comb begin
    acc = fin.accumulated_bits;
    status = (fin.kept_count != KEPT_TOTAL) || fin.bad_letter;
    if (status) begin
      ip_word = '0;
      port_number = '0;
    end else begin
      ip_word = {acc[23:16], acc[31:24], acc[39:32], acc[47:40]};
      port_number = acc[15:0];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sad_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sad_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] ip_word,
  input wire logic [15:0] port_number,
  input wire logic        status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result register not empty after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ip_word)
      && $stable(port_number) && $stable(status))
    else $error("Stalled result changed or was dropped.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> ip_word == 32'd0 && port_number == 16'd0)
    else $error("Error result carries a nonzero address.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the result side was free.");

  a_reset_no_stall: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("Input stalled right after reset.");

endmodule

bind syllable_address_decoder_unit sad_checker u_sad_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .ip_word     (ip_word),
  .port_number (port_number),
  .status      (status)
);
`default_nettype wire

@@ bench/addr_decode_checker.sv @@
`timescale 1ns / 1ps
module addr_decode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] ip_word,
  input  logic [15:0] port_number,
  input  logic        status,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          error_results
);
  import sad_pkg::*;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic        err;
  } addr_result_t;

  dec_state_t   shadow;
  addr_result_t expected_q[$];

  task automatic absorb_char(input logic [7:0] c);
    logic [7:0] u;
    int idx;
    if (shadow.ended || shadow.kept_count >= KEPT_TOTAL) return;
    if (c == CH_END) begin
      shadow.ended = 1'b1;
      return;
    end
    if (c == CH_DASH || c == CH_SPACE || c == CH_DOT || c == CH_UNDER) return;
    u = (c >= "a" && c <= "z") ? c - CASE_OFFSET : c;
    idx = -1;
    if (!shadow.kept_count[0]) begin
      for (int i = 0; i < CONS_COUNT; i++) if (CONS_TABLE[i] == u) idx = i;
      if (idx < 0) begin
        shadow.bad_letter = 1'b1;
        idx = 0;
      end
      shadow.accumulated_bits = {shadow.accumulated_bits[43:0], idx[3:0]};
    end else begin
      for (int i = 0; i < VOWEL_COUNT; i++) if (VOWEL_TABLE[i] == u) idx = i;
      if (idx < 0) begin
        shadow.bad_letter = 1'b1;
        idx = 0;
      end
      shadow.accumulated_bits = {shadow.accumulated_bits[45:0], idx[1:0]};
    end
    shadow.kept_count = shadow.kept_count + 5'd1;
  endtask

  function automatic addr_result_t close_string();
    addr_result_t r;
    logic [47:0] a;
    r = '0;
    a = shadow.accumulated_bits;
    r.err = (shadow.kept_count != KEPT_TOTAL) || shadow.bad_letter;
    if (!r.err) begin
      r.ip = {a[23:16], a[31:24], a[39:32], a[47:40]};
      r.port = a[15:0];
    end
    shadow = '0;
    return r;
  endfunction

  task automatic report(input bool_unexpected, input addr_result_t want, input addr_result_t seen);
    fail_count++;
    if (fail_count <= 10) begin
      if (bool_unexpected)
        $display("%0t: result with none expected: ip %h port %h err %b",
                 $time, seen.ip, seen.port, seen.err);
      else
        $display("%0t: mismatch: expected ip %h port %h err %b, got ip %h port %h err %b",
                 $time, want.ip, want.port, want.err, seen.ip, seen.port, seen.err);
    end
  endtask

  always @(posedge clk) begin
    addr_result_t seen;
    addr_result_t want;
    if (rst) begin
      shadow = '0;
      expected_q.delete();
      fail_count = 0;
      results_seen = 0;
      error_results = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.ip = ip_word;
        seen.port = port_number;
        seen.err = status;
        results_seen++;
        if (status) error_results++;
        if (expected_q.size() == 0) begin
          report(1'b1, '0, seen);
        end else begin
          want = expected_q.pop_front();
          if (seen.ip !== want.ip || seen.port !== want.port || seen.err !== want.err)
            report(1'b0, want, seen);
        end
      end
      if (in_valid && !in_stall) begin
        absorb_char(ch);
        if (last) expected_q.push_back(close_string());
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ bench/tb_syllable_address_decoder_unit.sv @@
`timescale 1ns / 1ps
module tb_syllable_address_decoder_unit;
  import sad_pkg::*;

  localparam int TARGET_ITEMS = 1850;
  localparam int CALM_FROM = 1550;
  localparam int LONG_HOLD = 300;
  localparam int IDLE_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  ch = 8'h00;
  logic        last = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] ip_word;
  logic [15:0] port_number;
  logic        status;

  int fail_count;
  int pending;
  int results_seen;
  int error_results;

  logic [7:0] str_q[$];
  int  useful_items = 0;
  int  items_sent = 0;
  int  strings_sent = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_idle_on = 1'b0;
  bit  long_hold_req = 1'b0;

  always #1 clk = ~clk;

  syllable_address_decoder_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .ch(ch), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .ip_word(ip_word), .port_number(port_number), .status(status)
  );

  addr_decode_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .ch(ch), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .ip_word(ip_word), .port_number(port_number), .status(status),
    .fail_count(fail_count), .pending(pending),
    .results_seen(results_seen), .error_results(error_results)
  );

  function automatic void add_item(input logic [7:0] c, input bit counted);
    str_q.push_back(c);
    if (counted) useful_items++;
  endfunction

  function automatic logic [7:0] pick_letter(input bit vowel);
    logic [7:0] c;
    c = vowel ? VOWEL_TABLE[$urandom_range(0, VOWEL_COUNT - 1)]
              : CONS_TABLE[$urandom_range(0, CONS_COUNT - 1)];
    if ($urandom_range(0, 1)) c = c + CASE_OFFSET;
    return c;
  endfunction

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 3))
      0: return CH_DASH;
      1: return CH_SPACE;
      2: return CH_DOT;
      default: return CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] pick_odd_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_DASH || c == CH_SPACE || c == CH_DOT || c == CH_UNDER);
    return c;
  endfunction

  function automatic void add_letters(input int n, input int bad_pos);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) add_item(pick_sep(), 1'b1);
      add_item(k == bad_pos ? pick_odd_byte() : pick_letter(k[0]), 1'b1);
    end
  endfunction

  function automatic void add_junk(input int n);
    for (int k = 0; k < n; k++) add_item(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  function automatic void build_random_string();
    int kind;
    str_q.delete();
    kind = $urandom_range(0, 19);
    if (kind < 12) begin
      add_letters(16, -1);
      if ($urandom_range(0, 2) == 0) add_junk($urandom_range(1, 6));
    end else if (kind < 14) begin
      add_letters(16, $urandom_range(0, 15));
      if ($urandom_range(0, 2) == 0) add_junk($urandom_range(1, 4));
    end else if (kind < 16) begin
      add_letters($urandom_range(0, 15), -1);
      add_item(CH_END, 1'b1);
      add_junk($urandom_range(0, 8));
    end else if (kind < 18) begin
      add_letters($urandom_range(0, 15), -1);
      if ($urandom_range(0, 1)) add_item(pick_sep(), 1'b1);
    end else begin
      for (int k = $urandom_range(1, 20); k > 0; k--) add_item(8'($urandom_range(0, 255)), 1'b1);
    end
    if (str_q.size() == 0) add_item(pick_sep(), 1'b1);
  endfunction

  function automatic void build_text(input string s);
    str_q.delete();
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b1);
  endfunction

  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    last <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++) send_char(str_q[i], i == str_q.size() - 1);
    strings_sent++;
  endtask

  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("Run stalled for %0d cycles with %0d results outstanding.", IDLE_LIMIT, pending);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    build_text("zozo-ZOZO.zozo_ZOZO");
    send_string();
    build_text("x");
    send_string();
    str_q.delete();
    add_item(CH_END, 1'b1);
    send_string();
    build_text("-");
    send_string();

    while (useful_items < TARGET_ITEMS) begin
      tx_idle_on = useful_items < CALM_FROM && $urandom_range(0, 3) != 0;
      rx_idle_on = useful_items < CALM_FROM && $urandom_range(0, 3) != 0;
      if (strings_sent == 6 || strings_sent == 50) long_hold_req = 1'b1;
      build_random_string();
      send_string();
    end
    in_valid <= 1'b0;
    rx_idle_on = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d characters in %0d strings; %0d results checked, %0d of them errors.",
             items_sent, strings_sent, results_seen, error_results);
    $display("Covered separators, case folding, overlong and cut-off strings, bad letters.");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
